// ===== src/stwq_pkg.sv =====
package stwq_pkg;

  // Field widths of one beat
  localparam int CMD_W  = 2;
  localparam int ID_W   = 32;
  localparam int TIME_W = 64;
  localparam int IDX_W  = 8;
  localparam int STAT_W = 3;
  localparam int OCNT_W = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_POP    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  localparam logic [STAT_W-1:0] ST_DONE     = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_NONE     = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_RANGE    = 3'd4;

  // What every cell does on each clock edge
  typedef enum logic [2:0] {
    ACT_HOLD,    // keep contents
    ACT_INSERT,  // open a slot and take the new entry
    ACT_SHIFT,   // every cell takes its right neighbor (pop head)
    ACT_MARK,    // load match flag and id copy for a sweep
    ACT_STEP,    // one doubling step of the sweep
    ACT_DROP     // cells at or after the first match take right neighbor
  } act_t;

  typedef struct packed {
    act_t              act;
    logic [TIME_W-1:0] deadline;
    logic [ID_W-1:0]   task_id;
    logic              take;
  } cell_ctl_t;

endpackage

// ===== src/stwq_if.sv =====
interface stwq_in_if import stwq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [ID_W-1:0]   task_id;
  logic [TIME_W-1:0] time_value;
  logic [IDX_W-1:0]  index;

  modport source (output valid, cmd, task_id, time_value, index, input ready);
  modport sink   (input valid, cmd, task_id, time_value, index, output ready);
endinterface

interface stwq_out_if import stwq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ID_W-1:0]   id_out;
  logic [TIME_W-1:0] next_deadline;
  logic [OCNT_W-1:0] count;

  modport source (output valid, status, id_out, next_deadline, count, input ready);
  modport sink   (input valid, status, id_out, next_deadline, count, output ready);
endinterface

// ===== src/stwq_cell.sv =====
module stwq_cell import stwq_pkg::*; (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic              occupied,
  input  logic              left_move,
  input  logic [TIME_W-1:0] left_dl,
  input  logic [ID_W-1:0]   left_id,
  input  logic [TIME_W-1:0] right_dl,
  input  logic [ID_W-1:0]   right_id,
  input  logic              far_found,
  input  logic [ID_W-1:0]   far_tmp,
  output logic [TIME_W-1:0] dl,
  output logic [ID_W-1:0]   id,
  output logic              move,
  output logic              found,
  output logic [ID_W-1:0]   tmp
);

  logic [TIME_W-1:0] dl_r;
  logic [ID_W-1:0]   id_r;
  logic              found_r;
  logic [ID_W-1:0]   tmp_r;

  // On insert this cell gives way when empty or holding a later deadline
  assign move  = !occupied || (dl_r > ctl.deadline);
  assign dl    = dl_r;
  assign id    = id_r;
  assign found = found_r;
  assign tmp   = tmp_r;

  always_ff @(posedge clk) begin
    case (ctl.act)
      ACT_INSERT: begin
        if (move) begin
          if (!left_move) begin
            dl_r <= ctl.deadline;
            id_r <= ctl.task_id;
          end else begin
            dl_r <= left_dl;
            id_r <= left_id;
          end
        end
      end
      ACT_SHIFT: begin
        dl_r <= right_dl;
        id_r <= right_id;
      end
      ACT_MARK: begin
        found_r <= occupied && (id_r == ctl.task_id);
        tmp_r   <= id_r;
      end
      ACT_STEP: begin
        // found spreads toward the tail, the id copy moves toward the head
        found_r <= found_r | far_found;
        if (ctl.take) tmp_r <= far_tmp;
      end
      ACT_DROP: begin
        if (found_r) begin
          dl_r <= right_dl;
          id_r <= right_id;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== src/sorted_timeout_wait_queue.sv =====
// Sorted timer queue: holds up to DEPTH (task id, deadline) entries in a row
// of cells kept in ascending deadline order, equal deadlines in arrival order.
// in_ch (sink) carries one command beat: cmd, task_id, time_value, index.
// out_ch (source) returns exactly one result beat per command: status, id_out,
// next_deadline (head deadline after the command, all ones when empty) and
// count (low 9 bits of the entry count).
// Insert and pop act on every cell at once, an out-of-range read on none;
// for these the result goes from the response state into the output
// register, and the next command is taken once that state is left.
// Remove by id and an in-range read sweep the cells in log2(DEPTH) doubling
// steps (a match flag spreads toward the tail, the id copy moves toward the
// head), then a finish state drops a matched entry or takes the read id.
// A single output register holds the result; while it waits for out_ch.ready
// the block takes and works on the next command, and only stalls before
// writing a second result into a full output register.
// Reset (rst_n low, synchronous) empties the queue and drops any pending
// result; entry contents are not cleared, only the count.
module sorted_timeout_wait_queue import stwq_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  logic clk,
  input  logic rst_n,
  stwq_in_if.sink    in_ch,
  stwq_out_if.source out_ch
);

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int LG     = $clog2(DEPTH);
  localparam int STEP_W = (LG > 1) ? $clog2(LG) : 1;
  localparam int NSEL   = 1 << STEP_W;

  typedef enum logic [1:0] {S_IDLE, S_STEP, S_FINISH, S_RESP} state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  count_r;
  logic [STEP_W-1:0] step_r;
  cmd_t              cmd_r;
  logic [IDX_W-1:0]  idx_r;
  logic [STAT_W-1:0] status_r;
  logic [ID_W-1:0]   res_id_r;
  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [ID_W-1:0]   out_id_r;
  logic [TIME_W-1:0] out_dl_r;
  logic [OCNT_W-1:0] out_cnt_r;

  logic [TIME_W-1:0] dl_w    [DEPTH];
  logic [ID_W-1:0]   id_w    [DEPTH];
  logic              move_w  [DEPTH];
  logic              found_w [DEPTH];
  logic [ID_W-1:0]   tmp_w   [DEPTH];
  logic              take_bit [NSEL];

  cell_ctl_t ctl;
  cmd_t      in_cmd;
  logic      in_accept;
  logic      full, empty;
  logic      ins_ok, pop_ok, rd_ok;

  assign in_cmd      = cmd_t'(in_ch.cmd);
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;

  assign full   = (count_r == CNT_W'(DEPTH));
  assign empty  = (count_r == '0);
  assign ins_ok = !full;
  assign pop_ok = !empty && (dl_w[0] <= in_ch.time_value);
  assign rd_ok  = 32'(in_ch.index) < 32'(count_r);

  // index bit that decides whether the id copy moves in each step
  for (genvar k = 0; k < NSEL; k++) begin : g_take
    if (k < IDX_W && k < LG) begin : g_on
      assign take_bit[k] = idx_r[k];
    end else begin : g_off
      assign take_bit[k] = 1'b0;
    end
  end

  // Cell command for this cycle
  always_comb begin
    ctl.act      = ACT_HOLD;
    ctl.deadline = in_ch.time_value;
    ctl.task_id  = in_ch.task_id;
    ctl.take     = take_bit[step_r];
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          case (in_cmd)
            CMD_INSERT: if (ins_ok) ctl.act = ACT_INSERT;
            CMD_POP:    if (pop_ok) ctl.act = ACT_SHIFT;
            CMD_REMOVE: ctl.act = ACT_MARK;
            CMD_READ:   if (rd_ok) ctl.act = ACT_MARK;
            default:    ctl.act = ACT_HOLD;
          endcase
        end
      end
      S_STEP:   ctl.act = ACT_STEP;
      S_FINISH: if (cmd_r == CMD_REMOVE && found_w[DEPTH-1]) ctl.act = ACT_DROP;
      default:  ctl.act = ACT_HOLD;
    endcase
  end

  // Row of cells with neighbor and doubling-distance links
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic              left_move_s;
    logic [TIME_W-1:0] left_dl_s, right_dl_s;
    logic [ID_W-1:0]   left_id_s, right_id_s;
    logic              cand_found [NSEL];
    logic [ID_W-1:0]   cand_tmp   [NSEL];
    logic              occ_s;

    if (i == 0) begin : g_head
      assign left_move_s = 1'b0;
      assign left_dl_s   = '0;
      assign left_id_s   = '0;
    end else begin : g_left
      assign left_move_s = move_w[i-1];
      assign left_dl_s   = dl_w[i-1];
      assign left_id_s   = id_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_dl_s = '0;
      assign right_id_s = '0;
    end else begin : g_right
      assign right_dl_s = dl_w[i+1];
      assign right_id_s = id_w[i+1];
    end

    for (genvar k = 0; k < NSEL; k++) begin : g_far
      if (k < LG && i >= (1 << k)) begin : g_ff
        assign cand_found[k] = found_w[i - (1 << k)];
      end else begin : g_fz
        assign cand_found[k] = 1'b0;
      end
      if (k < LG && i + (1 << k) < DEPTH) begin : g_tf
        assign cand_tmp[k] = tmp_w[i + (1 << k)];
      end else begin : g_tz
        assign cand_tmp[k] = '0;
      end
    end

    assign occ_s = CNT_W'(i) < count_r;

    stwq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occupied  (occ_s),
      .left_move (left_move_s),
      .left_dl   (left_dl_s),
      .left_id   (left_id_s),
      .right_dl  (right_dl_s),
      .right_id  (right_id_s),
      .far_found (cand_found[step_r]),
      .far_tmp   (cand_tmp[step_r]),
      .dl        (dl_w[i]),
      .id        (id_w[i]),
      .move      (move_w[i]),
      .found     (found_w[i]),
      .tmp       (tmp_w[i])
    );
  end

  // Sequencer, count and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // result valid: set when the response state loads, cleared once taken
      if (state_r == S_RESP && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            cmd_r    <= in_cmd;
            idx_r    <= in_ch.index;
            res_id_r <= (in_cmd == CMD_POP && pop_ok) ? id_w[0] : '0;
            step_r   <= '0;
            case (in_cmd)
              CMD_INSERT: begin
                status_r <= ins_ok ? ST_DONE : ST_FULL;
                if (ins_ok) count_r <= count_r + 1'b1;
                state_r <= S_RESP;
              end
              CMD_POP: begin
                if (pop_ok) begin
                  status_r <= ST_DONE;
                  count_r  <= count_r - 1'b1;
                end else begin
                  status_r <= ST_NONE;
                end
                state_r <= S_RESP;
              end
              CMD_REMOVE: begin
                status_r <= ST_NOTFOUND;
                state_r  <= S_STEP;
              end
              CMD_READ: begin
                if (rd_ok) begin
                  status_r <= ST_DONE;
                  state_r  <= S_STEP;
                end else begin
                  status_r <= ST_RANGE;
                  state_r  <= S_RESP;
                end
              end
              default: state_r <= S_RESP;
            endcase
          end
        end
        S_STEP: begin
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(LG - 1)) state_r <= S_FINISH;
        end
        S_FINISH: begin
          if (cmd_r == CMD_REMOVE) begin
            if (found_w[DEPTH-1]) begin
              status_r <= ST_DONE;
              count_r  <= count_r - 1'b1;
            end else begin
              status_r <= ST_NOTFOUND;
            end
          end else begin
            res_id_r <= tmp_w[0];
          end
          state_r <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid_r || out_ch.ready) begin
            out_status_r <= status_r;
            out_id_r     <= res_id_r;
            out_dl_r     <= empty ? '1 : dl_w[0];
            out_cnt_r    <= OCNT_W'(count_r);
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.id_out        = out_id_r;
  assign out_ch.next_deadline = out_dl_r;
  assign out_ch.count         = out_cnt_r;

`ifndef ASSERT_OFF
  // count stays within capacity
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  // accepted insert into a non-full queue grows the count by one
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_cmd == CMD_INSERT && !full) |=>
      (count_r == CNT_W'($past(count_r) + 1'b1)))
    else $error("insert did not add an entry");

  // the two leading entries are in deadline order
  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CNT_W'(2)) |-> (dl_w[0] <= dl_w[1]))
    else $error("head entries out of order");

  // a result beat is only raised from the response state
  a_resp_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESP))
    else $error("result raised outside response state");
`endif

endmodule
